[rtl/icrd_pkg.sv]
package icrd_pkg;

  // decoded bus event codes
  localparam logic [2:0] OP_START      = 3'd0;
  localparam logic [2:0] OP_ADDR_READ  = 3'd1;
  localparam logic [2:0] OP_ADDR_WRITE = 3'd2;
  localparam logic [2:0] OP_DATA_READ  = 3'd3;
  localparam logic [2:0] OP_DATA_WRITE = 3'd4;
  localparam logic [2:0] OP_STOP       = 3'd5;

  // result kinds
  localparam logic [2:0] KIND_READ_BYTE    = 3'd0;
  localparam logic [2:0] KIND_FULL_REPORT  = 3'd1;
  localparam logic [2:0] KIND_WRITE_BYTE   = 3'd2;
  localparam logic [2:0] KIND_INIT_OK      = 3'd3;
  localparam logic [2:0] KIND_INIT_LENGTH  = 3'd4;
  localparam logic [2:0] KIND_INIT_UNKNOWN = 3'd5;

  // report register slots
  localparam logic [2:0] REG_STICK_X = 3'd0;
  localparam logic [2:0] REG_STICK_Y = 3'd1;
  localparam logic [2:0] REG_ACCEL_X = 3'd2;
  localparam logic [2:0] REG_ACCEL_Y = 3'd3;
  localparam logic [2:0] REG_ACCEL_Z = 3'd4;
  localparam logic [2:0] REG_BUTTONS = 3'd5;

  localparam logic [5:0] ALL_VALID   = 6'h3F;
  localparam logic [7:0] INIT_FIRST  = 8'h40;
  localparam logic [7:0] INIT_SECOND = 8'h00;
  localparam logic [1:0] INIT_LEN    = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ADDR,
    PH_READ,
    PH_WRITE
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] reg_index;
    logic [7:0] echo_byte;
    logic [7:0] stick_x;
    logic [7:0] stick_y;
    logic [9:0] accel_x;
    logic [9:0] accel_y;
    logic [9:0] accel_z;
    logic       button_z;
    logic       button_c;
    logic [1:0] write_count;
  } result_t;

endpackage

[rtl/icrd_event_if.sv]
interface icrd_event_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] byte_value;

  modport source (output valid, operation, byte_value, input ready);
  modport sink (input valid, operation, byte_value, output ready);
endinterface

[rtl/icrd_result_if.sv]
interface icrd_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [2:0] reg_index;
  logic [7:0] echo_byte;
  logic [7:0] stick_x;
  logic [7:0] stick_y;
  logic [9:0] accel_x;
  logic [9:0] accel_y;
  logic [9:0] accel_z;
  logic       button_z;
  logic       button_c;
  logic [1:0] write_count;

  modport source (output valid, kind, reg_index, echo_byte, stick_x, stick_y, accel_x,
                  accel_y, accel_z, button_z, button_c, write_count, input ready);
  modport sink (input valid, kind, reg_index, echo_byte, stick_x, stick_y, accel_x,
                accel_y, accel_z, button_z, button_c, write_count, output ready);
endinterface

[rtl/i2c_controller_report_decoder.sv]
// I2C controller report decoder. Each request on evt is one decoded bus event
// (start, address read/write, data read/write, stop) plus its byte. A phase
// machine follows the transaction. Read bytes land in a six-slot report by a
// rolling index (stick X/Y, accel X/Y/Z high bits, then buttons and accel low
// bits) and are echoed; a read stop sends the full report when every slot was
// filled since the last read stop, and clears the slot flags either way.
// Write bytes are echoed, the first two are kept, and a write stop reports the
// init sequence as OK (0x40 0x00), wrong length, or unknown. Events that do
// not fit the current phase are dropped silently. Timing: two stages, an input
// register and a result register; one request per cycle sustained while rpt
// takes its results. A request is registered in the input register, then its
// result in the result register, which drives rpt until rpt takes it. A stalled
// rpt holds its result; once the input register also fills, evt is held too. The
// report index survives stops and is only cleared by reset.
module i2c_controller_report_decoder (
  input  logic                 clk,
  input  logic                 rst,
  icrd_event_if.sink           evt,
  icrd_result_if.source        rpt
);
  import icrd_pkg::*;

  // input stage
  logic       in_valid;
  logic [2:0] in_op;
  logic [7:0] in_byte;

  // decoder state
  phase_t     phase, phase_next;
  logic [2:0] report_index, report_index_next;
  logic [7:0] stick_x_reg, stick_x_reg_next;
  logic [7:0] stick_y_reg, stick_y_reg_next;
  logic [9:0] accel_x_reg, accel_x_reg_next;
  logic [9:0] accel_y_reg, accel_y_reg_next;
  logic [9:0] accel_z_reg, accel_z_reg_next;
  logic [1:0] button_bits, button_bits_next;
  logic [5:0] field_valid, field_valid_next;
  logic [7:0] init_bytes [2];
  logic [1:0] init_count, init_count_next;

  // result stage
  logic       out_valid;
  result_t    out_data;
  result_t    res;
  logic       res_valid;

  logic out_free;
  logic advance;

  assign out_free  = !out_valid || rpt.ready;
  assign advance   = in_valid && out_free;
  assign evt.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (evt.ready) begin
      in_valid <= evt.valid;
    end
    if (evt.ready && evt.valid) begin
      in_op   <= evt.operation;
      in_byte <= evt.byte_value;
    end
  end

  // next state
  always_comb begin
    phase_next        = phase;
    report_index_next = report_index;
    stick_x_reg_next  = stick_x_reg;
    stick_y_reg_next  = stick_y_reg;
    accel_x_reg_next  = accel_x_reg;
    accel_y_reg_next  = accel_y_reg;
    accel_z_reg_next  = accel_z_reg;
    button_bits_next  = button_bits;
    field_valid_next  = field_valid;
    init_count_next   = init_count;
    case (phase)
      PH_IDLE: begin
        if (in_op == OP_START) phase_next = PH_ADDR;
      end
      PH_ADDR: begin
        if (in_op == OP_ADDR_READ) phase_next = PH_READ;
        else if (in_op == OP_ADDR_WRITE) phase_next = PH_WRITE;
      end
      PH_READ: begin
        if (in_op == OP_DATA_READ) begin
          case (report_index)
            REG_STICK_X: begin
              stick_x_reg_next = in_byte;
              field_valid_next[0] = 1'b1;
            end
            REG_STICK_Y: begin
              stick_y_reg_next = in_byte;
              field_valid_next[1] = 1'b1;
            end
            REG_ACCEL_X: begin
              accel_x_reg_next = {in_byte, 2'b00};
              field_valid_next[2] = 1'b1;
            end
            REG_ACCEL_Y: begin
              accel_y_reg_next = {in_byte, 2'b00};
              field_valid_next[3] = 1'b1;
            end
            REG_ACCEL_Z: begin
              accel_z_reg_next = {in_byte, 2'b00};
              field_valid_next[4] = 1'b1;
            end
            REG_BUTTONS: begin
              // low accel bits are OR-ed in, they do not mark the field valid
              button_bits_next = in_byte[1:0];
              accel_x_reg_next = accel_x_reg | {8'd0, in_byte[3:2]};
              accel_y_reg_next = accel_y_reg | {8'd0, in_byte[5:4]};
              accel_z_reg_next = accel_z_reg | {8'd0, in_byte[7:6]};
              field_valid_next[5] = 1'b1;
            end
            default: ;
          endcase
          report_index_next = (report_index < REG_BUTTONS) ? report_index + 3'd1 : 3'd0;
        end else if (in_op == OP_STOP) begin
          field_valid_next = '0;
          phase_next       = PH_IDLE;
        end
      end
      PH_WRITE: begin
        if (in_op == OP_DATA_WRITE) begin
          if (init_count < INIT_LEN) init_count_next = init_count + 2'd1;
        end else if (in_op == OP_STOP) begin
          init_count_next = '0;
          phase_next      = PH_IDLE;
        end
      end
      default: phase_next = PH_IDLE;
    endcase
  end

  // result
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    case (phase)
      PH_READ: begin
        if (in_op == OP_DATA_READ) begin
          res_valid     = 1'b1;
          res.kind      = KIND_READ_BYTE;
          res.reg_index = report_index;
          res.echo_byte = in_byte;
        end else if (in_op == OP_STOP && field_valid == ALL_VALID) begin
          res_valid    = 1'b1;
          res.kind     = KIND_FULL_REPORT;
          res.stick_x  = stick_x_reg;
          res.stick_y  = stick_y_reg;
          res.accel_x  = accel_x_reg;
          res.accel_y  = accel_y_reg;
          res.accel_z  = accel_z_reg;
          res.button_z = button_bits[0];
          res.button_c = button_bits[1];
        end
      end
      PH_WRITE: begin
        if (in_op == OP_DATA_WRITE) begin
          res_valid       = 1'b1;
          res.kind        = KIND_WRITE_BYTE;
          res.echo_byte   = in_byte;
          res.write_count = init_count_next;
        end else if (in_op == OP_STOP) begin
          res_valid       = 1'b1;
          res.write_count = init_count;
          if (init_count != INIT_LEN) res.kind = KIND_INIT_LENGTH;
          else if (init_bytes[0] != INIT_FIRST || init_bytes[1] != INIT_SECOND)
            res.kind = KIND_INIT_UNKNOWN;
          else res.kind = KIND_INIT_OK;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      report_index <= '0;
      stick_x_reg  <= '0;
      stick_y_reg  <= '0;
      accel_x_reg  <= '0;
      accel_y_reg  <= '0;
      accel_z_reg  <= '0;
      button_bits  <= '0;
      field_valid  <= '0;
      init_count   <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      report_index <= report_index_next;
      stick_x_reg  <= stick_x_reg_next;
      stick_y_reg  <= stick_y_reg_next;
      accel_x_reg  <= accel_x_reg_next;
      accel_y_reg  <= accel_y_reg_next;
      accel_z_reg  <= accel_z_reg_next;
      button_bits  <= button_bits_next;
      field_valid  <= field_valid_next;
      init_count   <= init_count_next;
    end
  end

  // init byte capture, no reset needed: only read once both are written
  always_ff @(posedge clk) begin
    if (advance && phase == PH_WRITE && in_op == OP_DATA_WRITE && init_count < INIT_LEN) begin
      init_bytes[init_count[0]] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && res_valid;
    end
    if (advance && res_valid) begin
      out_data <= res;
    end
  end

  assign rpt.valid       = out_valid;
  assign rpt.kind        = out_data.kind;
  assign rpt.reg_index   = out_data.reg_index;
  assign rpt.echo_byte   = out_data.echo_byte;
  assign rpt.stick_x     = out_data.stick_x;
  assign rpt.stick_y     = out_data.stick_y;
  assign rpt.accel_x     = out_data.accel_x;
  assign rpt.accel_y     = out_data.accel_y;
  assign rpt.accel_z     = out_data.accel_z;
  assign rpt.button_z    = out_data.button_z;
  assign rpt.button_c    = out_data.button_c;
  assign rpt.write_count = out_data.write_count;

  // checks
  a_index_range: assert property (@(posedge clk) disable iff (rst)
    report_index <= REG_BUTTONS) else $error("report index out of range");

  a_count_sat: assert property (@(posedge clk) disable iff (rst)
    init_count <= INIT_LEN) else $error("init count above two");

  a_read_stop_clears: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_READ && in_op == OP_STOP |=> field_valid == '0 && phase == PH_IDLE)
    else $error("read stop did not clear flags");

  a_write_stop_clears: assert property (@(posedge clk) disable iff (rst)
    advance && phase == PH_WRITE && in_op == OP_STOP |=> init_count == '0 && phase == PH_IDLE)
    else $error("write stop did not clear count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rpt.ready |-> !advance) else $error("stage advanced over a held result");

endmodule
